// ----- rtl/core/slev_pkg.sv -----
// Shared types and constants for the sprite line evaluation block.
`default_nettype none

package slev_pkg;

    localparam int SPRITE_ENTRIES = 64;
    localparam int PER_LINE_LIMIT = 8;

    localparam int ENT_W = $clog2(SPRITE_ENTRIES);
    localparam int CNT_W = $clog2(PER_LINE_LIMIT + 1);

    localparam logic [7:0] Y_HEIGHT_SHORT = 8'd8;
    localparam logic [7:0] Y_HEIGHT_TALL  = 8'd16;

    typedef enum logic [1:0] {
        ACT_SET_PTR = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_EVAL    = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_TILE,
        S_ATTR,
        S_XPOS,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       set_ptr;
        logic       write;
        logic [7:0] value;
    } t_oam_cmd;

    typedef struct packed {
        logic       found;
        logic [2:0] slot;
        logic [5:0] source_index;
        logic [7:0] pos_y;
        logic [7:0] tile;
        logic [7:0] attributes;
        logic [7:0] pos_x;
        logic       overflow;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/slev_oam.sv -----
// Sprite attribute memory with its auto-incrementing byte pointer and registered read port.
`default_nettype none

module slev_oam
    import slev_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_oam_cmd i_cmd,
    input  wire logic [7:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [256];
    logic [7:0] r_ptr;
    logic [7:0] n_ptr;

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.set_ptr) begin
            n_ptr = i_cmd.value;
        end else if (i_cmd.write) begin
            n_ptr = r_ptr + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && !i_cmd.set_ptr) begin
            r_mem[r_ptr] <= i_cmd.value;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/sprite_line_evaluation_top.sv -----
// Top level of the sprite line evaluation block: command intake, scan sequencer, result output.
//
// The input channel carries commands: set the memory pointer, write a data byte at the
// pointer (the pointer then advances and wraps at 256), or evaluate a scanline. Pointer and
// data commands give no result. An evaluation scans the sprite entries in order through
// the single read port of the attribute memory: a Y read for each scanned entry, then tile,
// attributes and X reads for each selected entry, and a finishing step; a ninth match
// stops the scan early. The input is not ready during the scan, and is ready again once
// the final item has moved into the output register. Each selected sprite gives one
// output item, up to eight; the final one carries tlast and the overflow flag. A line
// with no sprite gives one item with found low. A selected sprite is held one step behind
// the scan so that tlast can be set on it; the scan stalls while that held item cannot
// move into a full, stalled output register.
// Reset clears the pointer, the tall-sprite setting and all control state; the memory
// contents stay undefined until written.
`default_nettype none

module sprite_line_evaluation_top
    import slev_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // value[7:0], scan_line[16:8], zero[23:17]
    input  wire logic [1:0]  i_s_tuser,   // action[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // slot, source_index, pos_y, tile, attributes,
                                          // pos_x, overflow, zero[47:42]
    output logic             o_m_tuser,   // found
    output logic             o_m_tlast
);

    t_state             r_state, n_state;
    logic [ENT_W:0]     r_entry, n_entry;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic               r_tall;
    t_result            r_pend, n_pend;
    logic               r_pend_valid, n_pend_valid;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               in_accept;
    t_action            action;
    logic [7:0]         in_value;
    logic [8:0]         in_line;
    logic [8:0]         r_line;
    t_oam_cmd           oam_cmd;
    logic [7:0]         rd_addr;
    logic [7:0]         rd_data;
    logic [1:0]         rd_byte;
    logic [9:0]         y_ext;
    logic [9:0]         y_end;
    logic               hit;
    logic               last_entry;
    logic               limit_hit;
    logic               out_free;
    logic               pend_busy;
    logic               load_out;

    assign in_accept  = i_s_tvalid && o_s_tready;
    assign action     = t_action'(i_s_tuser);
    assign in_value   = i_s_tdata[7:0];
    assign in_line    = i_s_tdata[16:8];
    assign o_s_tready = (r_state == S_IDLE);

    assign oam_cmd.set_ptr = in_accept && (action == ACT_SET_PTR);
    assign oam_cmd.write   = in_accept && (action == ACT_WRITE);
    assign oam_cmd.value   = in_value;

    // Shared compare unit: Y <= line < Y + height, evaluated at ten bits.
    assign y_ext      = {2'b00, rd_data};
    assign y_end      = y_ext + {2'b00, (r_tall ? Y_HEIGHT_TALL : Y_HEIGHT_SHORT)};
    assign hit        = (y_ext <= {1'b0, r_line}) && (y_end > {1'b0, r_line});
    assign last_entry = (r_entry == (ENT_W + 1)'(SPRITE_ENTRIES - 1));
    assign limit_hit  = (r_count >= CNT_W'(PER_LINE_LIMIT));
    assign out_free   = !r_out_valid || i_m_tready;
    assign pend_busy  = r_pend_valid && !out_free;

    always_comb begin
        n_state = r_state;
        n_entry = r_entry;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (action == ACT_EVAL)) begin
                    n_state = S_CHK;
                    n_entry = '0;
                end
            end
            S_CHK: begin
                if (hit) begin
                    if (limit_hit) begin
                        n_state = S_FIN;
                    end else if (!pend_busy) begin
                        n_state = S_TILE;
                    end
                end else if (last_entry) begin
                    n_state = S_FIN;
                end else begin
                    n_entry = r_entry + 1'b1;
                end
            end
            S_TILE: n_state = S_ATTR;
            S_ATTR: n_state = S_XPOS;
            S_XPOS: begin
                if (last_entry) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CHK;
                    n_entry = r_entry + 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        unique case (n_state)
            S_TILE:  rd_byte = 2'd1;
            S_ATTR:  rd_byte = 2'd2;
            S_XPOS:  rd_byte = 2'd3;
            default: rd_byte = 2'd0;
        endcase
        rd_addr = 8'({n_entry[ENT_W-1:0], rd_byte});
    end

    always_comb begin
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        load_out     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (action == ACT_EVAL)) begin
                    n_count      = '0;
                    n_ovf        = 1'b0;
                    n_pend_valid = 1'b0;
                end
            end
            S_CHK: begin
                if (hit && limit_hit) begin
                    n_ovf = 1'b1;
                end else if (hit && !pend_busy) begin
                    if (r_pend_valid) begin
                        load_out       = 1'b1;
                        n_out          = r_pend;
                        n_out.overflow = 1'b0;
                        n_out.last     = 1'b0;
                    end
                    n_pend_valid        = 1'b1;
                    n_pend.found        = 1'b1;
                    n_pend.slot         = 3'(r_count);
                    n_pend.source_index = 6'(r_entry[ENT_W-1:0]);
                    n_pend.pos_y        = rd_data;
                end
            end
            S_TILE: n_pend.tile       = rd_data;
            S_ATTR: n_pend.attributes = rd_data;
            S_XPOS: begin
                n_pend.pos_x = rd_data;
                n_count      = r_count + 1'b1;
            end
            S_FIN: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_pend_valid) begin
                        n_out          = r_pend;
                        n_out.overflow = r_ovf;
                    end else begin
                        n_out          = '0;
                    end
                    n_out.last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: ;
        endcase
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_entry      <= '0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_tall       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_entry      <= n_entry;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_tall <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (load_out) begin
            r_out <= n_out;
        end
        if (in_accept && (action == ACT_EVAL)) begin
            r_line <= in_line;
        end
    end

    slev_oam u_oam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (oam_cmd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.found;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {6'b0, r_out.overflow, r_out.pos_x, r_out.attributes, r_out.tile,
                         r_out.pos_y, r_out.source_index, r_out.slot};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PER_LINE_LIMIT))
        else $error("selected sprite count exceeds the per-line limit");

    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CNT_W'(PER_LINE_LIMIT)))
        else $error("overflow raised before the per-line limit was reached");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> o_m_tlast)
        else $error("empty result item is not the final item");

    a_fin_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && n_state == S_IDLE) |=> (o_m_tvalid && o_m_tlast))
        else $error("evaluation finished without a final result item");

endmodule

`default_nettype wire

// ----- tb/sprite_line_evaluation_top_test.sv -----
// Self-checking testbench for the sprite line evaluation block with a scanline scoreboard.
module sprite_line_evaluation_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import slev_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;

    class sprite_scoreboard;
        logic [7:0] oam [256];
        logic [7:0] ptr;
        logic       tall;
        t_result    pending[$];
        int         errors;
        int         shown;

        function new();
            ptr = '0;
            tall = 1'b0;
            errors = 0;
            shown = 0;
            foreach (oam[i]) oam[i] = '0;
        endfunction

        function void report(string msg);
            errors++;
            if (shown < 50) begin
                shown++;
                $display("MISMATCH at %0t ns: %s", $time, msg);
            end
        endfunction

        function void note_item(logic [1:0] act, logic [7:0] value, logic [8:0] scan_ln);
            int        height;
            int        count;
            int        y;
            bit        ovf;
            t_result   r;
            t_result   sel[$];
            case (act)
                ACT_SET_PTR: ptr = value;
                ACT_WRITE: begin
                    oam[ptr] = value;
                    ptr++;
                end
                ACT_EVAL: begin
                    height = tall ? 16 : 8;
                    count = 0;
                    ovf = 1'b0;
                    for (int e = 0; e < SPRITE_ENTRIES; e++) begin
                        y = int'(oam[4 * e]);
                        if (y <= int'(scan_ln) && y + height > int'(scan_ln)) begin
                            if (count >= PER_LINE_LIMIT) begin
                                ovf = 1'b1;
                                break;
                            end
                            r = '0;
                            r.found = 1'b1;
                            r.slot = count[2:0];
                            r.source_index = e[5:0];
                            r.pos_y = oam[4 * e];
                            r.tile = oam[4 * e + 1];
                            r.attributes = oam[4 * e + 2];
                            r.pos_x = oam[4 * e + 3];
                            sel.push_back(r);
                            count++;
                        end
                    end
                    if (count == 0) begin
                        r = '0;
                        r.last = 1'b1;
                        sel.push_back(r);
                    end else begin
                        r = sel.pop_back();
                        r.last = 1'b1;
                        r.overflow = ovf;
                        sel.push_back(r);
                    end
                    foreach (sel[i]) pending.push_back(sel[i]);
                end
                default: ;
            endcase
        endfunction

        function void compare(string name, logic [7:0] got_v, logic [7:0] want_v);
            if (got_v !== want_v)
                report($sformatf("%s got %h expected %h", name, got_v, want_v));
        endfunction

        function void check_result(logic found, logic [47:0] data, logic last);
            t_result got;
            t_result want;
            got.found = found;
            got.slot = data[2:0];
            got.source_index = data[8:3];
            got.pos_y = data[16:9];
            got.tile = data[24:17];
            got.attributes = data[32:25];
            got.pos_x = data[40:33];
            got.overflow = data[41];
            got.last = last;
            if (pending.size() == 0) begin
                report($sformatf("item with nothing pending, data %h", data));
                return;
            end
            want = pending.pop_front();
            compare("found", {7'd0, got.found}, {7'd0, want.found});
            compare("slot", {5'd0, got.slot}, {5'd0, want.slot});
            compare("source_index", {2'd0, got.source_index}, {2'd0, want.source_index});
            compare("pos_y", got.pos_y, want.pos_y);
            compare("tile", got.tile, want.tile);
            compare("attributes", got.attributes, want.attributes);
            compare("pos_x", got.pos_x, want.pos_x);
            compare("overflow", {7'd0, got.overflow}, {7'd0, want.overflow});
            compare("last", {7'd0, got.last}, {7'd0, want.last});
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // value[7:0], scan_line[16:8], zero[23:17]
    logic [1:0]  s_tuser = '0;     // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // slot, source_index, pos_y, tile, attributes,
                                   // pos_x, overflow, zero[47:42]
    logic        m_tuser;          // found
    logic        m_tlast;

    bit          no_idle = 1'b0;
    bit          long_hold = 1'b0;
    logic [7:0]  hot_y = 8'd40;

    sprite_scoreboard sb = new();

    sprite_line_evaluation_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [7:0] value,
                             input logic [8:0] scan_ln);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {7'd0, scan_ln, value};
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_item(act, value, scan_ln);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_tall(input logic tall);
        cfg_we <= 1'b1;
        cfg_wdata <= tall;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.tall = tall;
    endtask

    task automatic rewrite_entry(input int e);
        send_item(ACT_SET_PTR, 8'(4 * e), 9'($urandom_range(0, 511)));
        if ($urandom_range(0, 99) < 65)
            send_item(ACT_WRITE, hot_y + 8'($urandom_range(0, 12)), 9'($urandom_range(0, 511)));
        else
            send_item(ACT_WRITE, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
        repeat (3) send_item(ACT_WRITE, 8'($urandom), 9'($urandom_range(0, 511)));
    endtask

    task automatic random_phase(input int quota);
        int sent;
        int r;
        sent = 0;
        while (sent < quota) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                rewrite_entry($urandom_range(0, SPRITE_ENTRIES - 1));
                sent += 5;
            end else if (r < 75) begin
                if ($urandom_range(0, 99) < 70)
                    send_item(ACT_EVAL, 8'($urandom), 9'(hot_y) + 9'($urandom_range(0, 20)));
                else
                    send_item(ACT_EVAL, 8'($urandom), 9'($urandom_range(0, 511)));
                sent++;
            end else if (r < 85) begin
                send_item(ACT_SET_PTR, 8'($urandom), 9'($urandom_range(0, 511)));
                sent++;
            end else if (r < 95) begin
                send_item(ACT_WRITE, 8'($urandom), 9'($urandom_range(0, 511)));
                sent++;
            end else begin
                send_item(ACT_UNUSED, 8'($urandom), 9'($urandom_range(0, 511)));
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    initial begin
        int gap;
        @(posedge clk iff rst_n);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end else begin
                gap = gap_len();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial begin
        logic [7:0] b;
        int e;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the whole attribute memory: a cluster of ten sprites on line 100, exactly
        // eight on line 150, the extreme Y values in the last two entries.
        send_item(ACT_SET_PTR, 8'd0, 9'd0);
        for (int i = 0; i < 256; i++) begin
            e = i / 4;
            if (i % 4 == 0) begin
                if (e < 10) b = 8'd100;
                else if (e < 18) b = 8'd150;
                else if (e == 62) b = 8'd0;
                else if (e == 63) b = 8'd255;
                else b = 8'($urandom_range(170, 250));
            end else if (e == 0) begin
                b = 8'hFF;
            end else if (e == 1) begin
                b = 8'h00;
            end else begin
                b = 8'($urandom);
            end
            send_item(ACT_WRITE, b, 9'($urandom_range(0, 511)));
        end

        send_item(ACT_EVAL, 8'd0, 9'd100);
        send_item(ACT_EVAL, 8'hFF, 9'd150);
        send_item(ACT_EVAL, 8'd0, 9'd0);
        send_item(ACT_EVAL, 8'd0, 9'd255);
        send_item(ACT_EVAL, 8'd0, 9'd262);
        send_item(ACT_EVAL, 8'd0, 9'd511);
        send_item(ACT_EVAL, 8'd0, 9'd60);
        send_item(ACT_UNUSED, 8'hFF, 9'h1FF);
        send_item(ACT_SET_PTR, 8'hFF, 9'd0);
        send_item(ACT_WRITE, 8'hC3, 9'd0);
        send_item(ACT_WRITE, 8'd100, 9'd0);
        send_item(ACT_EVAL, 8'd0, 9'd262);
        send_item(ACT_SET_PTR, 8'd4, 9'd0);
        send_item(ACT_WRITE, 8'd200, 9'd0);
        send_item(ACT_EVAL, 8'd0, 9'd100);
        wait_idle();

        write_tall(1'b1);
        send_item(ACT_EVAL, 8'd0, 9'd115);
        send_item(ACT_EVAL, 8'd0, 9'd270);
        send_item(ACT_EVAL, 8'd0, 9'd165);
        wait_idle();

        write_tall(1'b0);
        hot_y = 8'd40;
        random_phase(20);
        wait_idle();

        write_tall(1'b1);
        no_idle = 1'b1;
        hot_y = 8'd120;
        random_phase(20);
        no_idle = 1'b0;
        wait_idle();

        // The output is held off while evaluations keep coming, so the input backs up.
        write_tall(1'b0);
        hot_y = 8'd200;
        long_hold = 1'b1;
        repeat (12) send_item(ACT_EVAL, 8'd0, 9'(hot_y) + 9'($urandom_range(0, 8)));
        random_phase(20);
        wait_idle();

        write_tall(1'b1);
        hot_y = 8'd238;
        random_phase(20);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("sprite_line_evaluation_top regression: pass");
        else
            $display("sprite_line_evaluation_top regression: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sprite_line_evaluation_top regression: fail");
        $finish;
    end

endmodule
